FILE: hw/rtl/fgch_pkg.sv
`default_nettype none
package fgch_pkg;

   localparam int unsigned SlotLog2  = 12;
   localparam int unsigned SlotDepth = 1 << SlotLog2;
   localparam int unsigned PtrBits   = SlotLog2 + 1;
   localparam int unsigned MinLog2   = 10;
   localparam int unsigned KeyBits   = 64;
   localparam int unsigned CountBits = 32;
   localparam int unsigned IdxBits   = 3;

   localparam logic [63:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;

   // commands
   localparam logic [1:0] CMD_ROW   = 2'd0;
   localparam logic [1:0] CMD_FETCH = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // result status codes
   localparam logic [2:0] STATUS_COUNTED  = 3'd0;
   localparam logic [2:0] STATUS_FILTERED = 3'd1;
   localparam logic [2:0] STATUS_FULL     = 3'd2;
   localparam logic [2:0] STATUS_GROUP    = 3'd3;
   localparam logic [2:0] STATUS_NO_MORE  = 3'd4;
   localparam logic [2:0] STATUS_CLEARED  = 3'd5;

   // register indexes
   localparam logic [IdxBits-1:0] REG_SIZE_LOG2  = 3'd0;
   localparam logic [IdxBits-1:0] REG_NOT_EQUAL  = 3'd1;
   localparam logic [IdxBits-1:0] REG_CMP_WIDTH  = 3'd2;
   localparam logic [IdxBits-1:0] REG_CONSTANT   = 3'd3;
   localparam logic [IdxBits-1:0] REG_KNOWN      = 3'd4;

   // compare widths
   localparam logic [1:0] CMP_W8  = 2'd0;
   localparam logic [1:0] CMP_W16 = 2'd1;
   localparam logic [1:0] CMP_W32 = 2'd2;
   localparam logic [1:0] CMP_W64 = 2'd3;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_CROSS,
      ST_HASH,
      ST_PROBE,
      ST_DRAIN,
      ST_LOOK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 used;
      logic [KeyBits-1:0]   key;
      logic [CountBits-1:0] count;
   } slot_type;

   localparam int unsigned SlotBits = $bits(slot_type);

endpackage
`default_nettype wire

FILE: hw/rtl/fgch_if.sv
`default_nettype none
interface fgch_req_if;
   import fgch_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [63:0] filter_value;
   logic [63:0] group_key;
   modport source (output valid, cmd, filter_value, group_key, input ready);
   modport sink (input valid, cmd, filter_value, group_key, output ready);
endinterface

interface fgch_rsp_if;
   import fgch_pkg::*;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] out_key;
   logic [31:0] out_count;
   logic        last_group;
   modport source (output valid, status, out_key, out_count, last_group, input ready);
   modport sink (input valid, status, out_key, out_count, last_group, output ready);
endinterface

interface fgch_csr_if;
   import fgch_pkg::*;
   logic               valid;
   logic               ready;
   logic [IdxBits-1:0] index;
   logic [63:0]        data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/fgch_ram.sv
`default_nettype none
module fgch_ram #(
   parameter int unsigned ADDR_BITS = 12,
   parameter int unsigned DATA_BITS = 97
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: hw/rtl/filtered_group_count_hash_top.sv
`default_nettype none
// filtered group-by-count engine. a row transfer (cmd 0) is filtered against the configured
// constant and, if it passes, its key is hashed and counted in a linear-probing table of
// 1024 to 4096 slots held in one synchronous ram. a fetch transfer (cmd 1) returns the next
// occupied slot in slot order and flags the last one; a clear transfer (cmd 2) empties the
// table. one item is worked at a time, one result per item. a filtered row goes straight to
// the result; a counted row passes three multiply states and a hash state, then reads one
// ram slot per probe. a fetch examines each slot from the drain pointer through the returned
// slot and on to the next occupied one or the end of the table. after reset and on every
// clear the ram is swept, all 4096 slots, one slot a cycle, while no item is taken;
// configuration writes are taken at any time but must only be made while the block is idle.
module filtered_group_count_hash_top (
   input wire logic clock,
   input wire logic reset,
   fgch_req_if.sink   req_ch,
   fgch_rsp_if.source rsp_ch,
   fgch_csr_if.sink   csr_ch
);
   import fgch_pkg::*;

   // configuration registers
   logic [3:0]  size_log2_ff;
   logic        not_equal_ff;
   logic [1:0]  cmp_width_ff;
   logic [63:0] constant_ff;
   logic        known_ff;

   // control
   state_type          state_ff, state_in;
   logic [PtrBits-1:0] ptr_ff, ptr_in;
   logic [PtrBits-1:0] drain_ff, drain_in;
   logic [PtrBits-1:0] probes_ff, probes_in;
   logic               reply_ff, reply_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [KeyBits-1:0]   key_ff, key_in;
   logic [63:0]          p0_ff, p0_in;
   logic [31:0]          cross_ff, cross_in;
   logic [2:0]           res_status_ff, res_status_in;
   logic [KeyBits-1:0]   res_key_ff, res_key_in;
   logic [CountBits-1:0] res_count_ff, res_count_in;
   logic                 res_last_ff, res_last_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [KeyBits-1:0]   rsp_key_ff, rsp_key_in;
   logic [CountBits-1:0] rsp_count_ff, rsp_count_in;
   logic                 rsp_last_ff, rsp_last_in;

   // ram port
   logic                wr_en;
   logic [SlotLog2-1:0] wr_addr;
   slot_type            wr_slot;
   slot_type            rd_slot;
   logic [SlotBits-1:0] rd_word;

   // shared 32x32 multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_prod;

   // derived
   logic [3:0]          lg_eff;
   logic [PtrBits-1:0]  size;
   logic [SlotLog2-1:0] mask;
   logic [63:0]         cmp_mask;
   logic                row_pass;
   logic [63:0]         hash;
   logic [SlotLog2-1:0] home;

   fgch_ram #(
      .ADDR_BITS(SlotLog2),
      .DATA_BITS(SlotBits)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_slot),
      .rd_addr(ptr_in[SlotLog2-1:0]),
      .rd_data(rd_word)
   );

   assign rd_slot = slot_type'(rd_word);

   // clamp the table size to the supported range
   always_comb begin
      if (size_log2_ff < 4'(MinLog2)) begin
         lg_eff = 4'(MinLog2);
      end else if (size_log2_ff > 4'(SlotLog2)) begin
         lg_eff = 4'(SlotLog2);
      end else begin
         lg_eff = size_log2_ff;
      end
   end

   assign size = PtrBits'(1) << lg_eff;
   assign mask = SlotLog2'(size - PtrBits'(1));

   // filter compare
   always_comb begin
      unique case (cmp_width_ff)
         CMP_W8:  cmp_mask = 64'h0000_0000_0000_00FF;
         CMP_W16: cmp_mask = 64'h0000_0000_0000_FFFF;
         CMP_W32: cmp_mask = 64'h0000_0000_FFFF_FFFF;
         CMP_W64: cmp_mask = 64'hFFFF_FFFF_FFFF_FFFF;
         default: cmp_mask = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
   end

   assign row_pass = (known_ff && (((req_ch.filter_value ^ constant_ff) & cmp_mask) == 64'd0))
                     ^ not_equal_ff;

   // low 64 bits of key * golden: low product plus the two cross terms shifted up
   assign mul_prod = mul_a * mul_b;
   assign hash     = {p0_ff[63:32] + cross_ff, p0_ff[31:0]};
   assign home     = (hash[SlotLog2-1:0] ^ hash[33 +: SlotLog2]) & mask;

   // configuration port
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= 4'(MinLog2);
         not_equal_ff <= 1'b0;
         cmp_width_ff <= CMP_W64;
         constant_ff  <= 64'd0;
         known_ff     <= 1'b1;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_SIZE_LOG2: size_log2_ff <= csr_ch.data[3:0];
            REG_NOT_EQUAL: not_equal_ff <= csr_ch.data[0];
            REG_CMP_WIDTH: cmp_width_ff <= csr_ch.data[1:0];
            REG_CONSTANT:  constant_ff  <= csr_ch.data;
            REG_KNOWN:     known_ff     <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      drain_in      = drain_ff;
      probes_in     = probes_ff;
      reply_in      = reply_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      key_in        = key_ff;
      p0_in         = p0_ff;
      cross_in      = cross_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_count_in  = res_count_ff;
      res_last_in   = res_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff[SlotLog2-1:0];
      wr_slot       = '0;
      mul_a         = key_ff[31:0];
      mul_b         = GOLDEN[31:0];
      req_ch.ready  = 1'b0;

      unique case (state_ff)
         ST_SWEEP: begin
            // write every slot as free
            wr_en = 1'b1;
            if (ptr_ff == PtrBits'(SlotDepth - 1)) begin
               reply_in      = 1'b0;
               res_status_in = STATUS_CLEARED;
               state_in      = reply_ff ? ST_DONE : ST_IDLE;
            end else begin
               ptr_in = ptr_ff + PtrBits'(1);
            end
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               key_in        = req_ch.group_key;
               res_key_in    = '0;
               res_count_in  = '0;
               res_last_in   = 1'b0;
               res_status_in = STATUS_FILTERED;
               unique case (req_ch.cmd)
                  CMD_ROW:   state_in = row_pass ? ST_MUL_LO : ST_DONE;
                  CMD_FETCH: begin
                     ptr_in   = drain_ff;
                     state_in = ST_DRAIN;
                  end
                  CMD_CLEAR: begin
                     ptr_in   = '0;
                     drain_in = '0;
                     reply_in = 1'b1;
                     state_in = ST_SWEEP;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_MUL_LO: begin
            p0_in    = mul_prod;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mul_a    = key_ff[63:32];
            cross_in = mul_prod[31:0];
            state_in = ST_MUL_CROSS;
         end
         ST_MUL_CROSS: begin
            mul_b    = GOLDEN[63:32];
            cross_in = cross_ff + mul_prod[31:0];
            state_in = ST_HASH;
         end
         ST_HASH: begin
            ptr_in    = {1'b0, home};
            probes_in = '0;
            state_in  = ST_PROBE;
         end
         ST_PROBE: begin
            // ram data belongs to ptr_ff; a miss issues the next read at once
            if (!rd_slot.used) begin
               wr_en         = 1'b1;
               wr_slot.used  = 1'b1;
               wr_slot.key   = key_ff;
               wr_slot.count = CountBits'(1);
               res_status_in = STATUS_COUNTED;
               state_in      = ST_DONE;
            end else if (rd_slot.key == key_ff) begin
               wr_en         = 1'b1;
               wr_slot       = rd_slot;
               if (rd_slot.count != '1) begin
                  wr_slot.count = rd_slot.count + CountBits'(1);
               end
               res_status_in = STATUS_COUNTED;
               state_in      = ST_DONE;
            end else if (probes_ff == size - PtrBits'(1)) begin
               res_status_in = STATUS_FULL;
               state_in      = ST_DONE;
            end else begin
               probes_in = probes_ff + PtrBits'(1);
               ptr_in    = {1'b0, (ptr_ff[SlotLog2-1:0] + SlotLog2'(1)) & mask};
            end
         end
         ST_DRAIN: begin
            if (ptr_ff >= size) begin
               drain_in      = size;
               res_status_in = STATUS_NO_MORE;
               state_in      = ST_DONE;
            end else if (rd_slot.used) begin
               res_status_in = STATUS_GROUP;
               res_key_in    = rd_slot.key;
               res_count_in  = rd_slot.count;
               drain_in      = ptr_ff + PtrBits'(1);
               ptr_in        = ptr_ff + PtrBits'(1);
               state_in      = ST_LOOK;
            end else begin
               ptr_in = ptr_ff + PtrBits'(1);
            end
         end
         ST_LOOK: begin
            // look ahead for another occupied slot to set the last flag
            if (ptr_ff >= size) begin
               res_last_in = 1'b1;
               state_in    = ST_DONE;
            end else if (rd_slot.used) begin
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_ff + PtrBits'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_key_in    = res_key_ff;
               rsp_count_in  = res_count_ff;
               rsp_last_in   = res_last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         ptr_ff       <= '0;
         drain_ff     <= '0;
         probes_ff    <= '0;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         drain_ff     <= drain_in;
         probes_ff    <= probes_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      p0_ff         <= p0_in;
      cross_ff      <= cross_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_count_ff  <= res_count_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.out_key    = rsp_key_ff;
   assign rsp_ch.out_count  = rsp_count_ff;
   assign rsp_ch.last_group = rsp_last_ff;

   // ram writes only come from the sweep or a probe hit
   a_write_source : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_SWEEP || state_ff == ST_PROBE))
      else $error("ram write outside sweep or probe");

   // drain pointer never passes the largest table
   a_drain_range : assert property (@(posedge clock) disable iff (reset)
      drain_ff <= PtrBits'(SlotDepth))
      else $error("drain pointer out of range");

   // probe count stays below the table size
   a_probe_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (probes_ff < size))
      else $error("probe count overran table");

   // a returned group always carries a nonzero count
   a_group_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_GROUP) |-> (rsp_count_ff != '0))
      else $error("group returned with zero count");

   // a new result is only loaded once the previous one has gone
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> $stable(rsp_status_ff))
      else $error("pending result overwritten");

endmodule
`default_nettype wire
